[design/dsa_pkg.sv]
`default_nettype none

package dsa_pkg;

  // field widths
  localparam int MotionW = 8;
  localparam int WheelW  = 8;
  localparam int TimeW   = 16;
  localparam int AccW    = 32;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 16;

  // number of restoring division steps, one quotient bit each
  localparam int DivSteps = AccW;
  localparam int DivCntW  = $clog2(DivSteps);

  // largest wheel value reported
  localparam int WheelLimit = 127;

  // reset values of the configuration registers
  localparam logic [7:0]       UnitsReset   = 8'd1;
  localparam logic [7:0]       DivisorReset = 8'd6;
  localparam logic [TimeW-1:0] TimeoutReset = 16'd100;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCROLL_ENABLE    = 2'd0,
    CFG_UNITS_PER_DETENT = 2'd1,
    CFG_DETENT_DIVISOR   = 2'd2,
    CFG_SNAP_TIMEOUT_MS  = 2'd3
  } cfg_idx_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_DIV,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic add;
    logic step;
    logic commit;
  } dsa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic enable;
    logic div_last;
    logic out_free;
  } dsa_status_t;

endpackage

`default_nettype wire

[design/dsa_motion_if.sv]
`default_nettype none

interface dsa_motion_if import dsa_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [MotionW-1:0] motion_x;
  logic signed [MotionW-1:0] motion_y;
  logic signed [WheelW-1:0]  wheel_h_in;
  logic signed [WheelW-1:0]  wheel_v_in;
  logic [TimeW-1:0]          now_ms;

  modport source (output valid, motion_x, motion_y, wheel_h_in, wheel_v_in, now_ms,
                  input ready);
  modport sink (input valid, motion_x, motion_y, wheel_h_in, wheel_v_in, now_ms,
                output ready);
endinterface

`default_nettype wire

[design/dsa_report_if.sv]
`default_nettype none

interface dsa_report_if import dsa_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [MotionW-1:0] out_x;
  logic signed [MotionW-1:0] out_y;
  logic signed [WheelW-1:0]  out_wheel_h;
  logic signed [WheelW-1:0]  out_wheel_v;

  modport source (output valid, out_x, out_y, out_wheel_h, out_wheel_v, input ready);
  modport sink (input valid, out_x, out_y, out_wheel_h, out_wheel_v, output ready);
endinterface

`default_nettype wire

[design/dsa_cfg_if.sv]
`default_nettype none

interface dsa_cfg_if import dsa_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/dsa_ctrl.sv]
`default_nettype none

module dsa_ctrl import dsa_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  dsa_status_t status,
  output dsa_cmd_t    cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = status.enable ? ST_ADD : ST_DONE;
        end
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/dsa_datapath.sv]
`default_nettype none

module dsa_datapath import dsa_pkg::*; (
  input  wire                        clk,
  input  wire                        rst,
  input  dsa_cmd_t                   cmd,
  output dsa_status_t                status,
  // configuration write
  input  wire                        cfg_we,
  input  wire [CfgIdxW-1:0]          cfg_index,
  input  wire [CfgDatW-1:0]          cfg_data,
  // input payload
  input  wire signed [MotionW-1:0]   motion_x,
  input  wire signed [MotionW-1:0]   motion_y,
  input  wire signed [WheelW-1:0]    wheel_h_in,
  input  wire signed [WheelW-1:0]    wheel_v_in,
  input  wire [TimeW-1:0]            now_ms,
  // output register
  input  wire                        out_ready,
  output logic                       out_valid,
  output logic signed [MotionW-1:0]  out_x,
  output logic signed [MotionW-1:0]  out_y,
  output logic signed [WheelW-1:0]   out_wheel_h,
  output logic signed [WheelW-1:0]   out_wheel_v
);

  // configuration registers
  logic             scroll_enable;
  logic [7:0]       units;
  logic [7:0]       divisor;
  logic [TimeW-1:0] timeout;

  // persistent scroll state
  logic signed [AccW-1:0] acc_h;
  logic signed [AccW-1:0] acc_v;
  logic [TimeW-1:0]       last_time;
  logic                   locked;
  logic                   vert;

  // captured transaction
  logic signed [MotionW-1:0] mx;
  logic signed [MotionW-1:0] my;
  logic signed [WheelW-1:0]  wh;
  logic signed [WheelW-1:0]  wv;
  logic [TimeW-1:0]          now_q;

  // working accumulators and divider
  logic signed [AccW-1:0] wah;
  logic signed [AccW-1:0] wav;
  logic [AccW-1:0]        dq_h;
  logic [AccW-1:0]        dq_v;
  logic [7:0]             rem_h;
  logic [7:0]             rem_v;
  logic [DivCntW-1:0]     cnt;

  function automatic logic signed [AccW-1:0] sat33(input logic signed [AccW:0] v);
    logic signed [AccW-1:0] r;
    if (v[AccW] != v[AccW-1]) begin
      r = v[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      r = v[AccW-1:0];
    end
    return r;
  endfunction

  function automatic logic [AccW-1:0] magn(input logic signed [AccW-1:0] v);
    return v[AccW-1] ? AccW'(-v) : AccW'(v);
  endfunction

  logic [7:0] div_eff;
  logic       locking;
  assign div_eff = (divisor == 8'd0) ? 8'd1 : divisor;
  assign locking = (timeout != '0);

  // add stage: motion times units, saturating add, still-timeout release
  logic signed [16:0]     prod_h, prod_v;
  logic signed [AccW:0]   sum_h, sum_v;
  logic signed [AccW-1:0] add_h, add_v;
  logic                   moving, release_lock;
  logic [TimeW-1:0]       elapsed;

  always_comb begin
    prod_h       = 17'(mx) * 17'($signed({1'b0, units}));
    prod_v       = 17'(my) * 17'($signed({1'b0, units}));
    sum_h        = {acc_h[AccW-1], acc_h} + (AccW+1)'(prod_h);
    sum_v        = {acc_v[AccW-1], acc_v} + (AccW+1)'(prod_v);
    moving       = (mx != '0) || (my != '0);
    elapsed      = now_q - last_time;
    release_lock = locking && !moving && locked && (elapsed > timeout);
    add_h        = release_lock ? '0 : sat33(sum_h);
    add_v        = release_lock ? '0 : sat33(sum_v);
  end

  // one restoring division step per axis
  logic [8:0] trial_h, trial_v;
  logic       ge_h, ge_v;

  always_comb begin
    trial_h = {rem_h, dq_h[AccW-1]};
    trial_v = {rem_v, dq_v[AccW-1]};
    ge_h    = trial_h >= {1'b0, div_eff};
    ge_v    = trial_v >= {1'b0, div_eff};
  end

  // finish: lock decision, axis snap, clamp and subtract reported detents
  logic                   lock_new, locked_n, vert_n;
  logic                   nz_h, nz_v, zero_h, zero_v, tick_h, tick_v;
  logic [6:0]             qc_h, qc_v;
  logic signed [WheelW-1:0] whl_h, whl_v;
  logic signed [16:0]     dec_h, dec_v;
  logic signed [AccW-1:0] az_h, az_v, fin_h, fin_v;

  always_comb begin
    nz_h     = (dq_h != '0);
    nz_v     = (dq_v != '0);
    lock_new = locking && !locked && (nz_h || nz_v);
    locked_n = locked || lock_new;
    vert_n   = lock_new ? (dq_v >= dq_h) : vert;
    zero_h   = locking && locked_n && vert_n;
    zero_v   = locking && locked_n && !vert_n;
    az_h     = zero_h ? '0 : wah;
    az_v     = zero_v ? '0 : wav;
    tick_h   = !zero_h && nz_h;
    tick_v   = !zero_v && nz_v;
    qc_h     = (dq_h > AccW'(WheelLimit)) ? 7'(WheelLimit) : dq_h[6:0];
    qc_v     = (dq_v > AccW'(WheelLimit)) ? 7'(WheelLimit) : dq_v[6:0];
    whl_h    = wah[AccW-1] ? -$signed({1'b0, qc_h}) : $signed({1'b0, qc_h});
    whl_v    = wav[AccW-1] ? -$signed({1'b0, qc_v}) : $signed({1'b0, qc_v});
    dec_h    = 17'(whl_h) * 17'($signed({1'b0, div_eff}));
    dec_v    = 17'(whl_v) * 17'($signed({1'b0, div_eff}));
    fin_h    = tick_h ? az_h - AccW'(dec_h) : az_h;
    fin_v    = tick_v ? az_v - AccW'(dec_v) : az_v;
  end

  // configuration, scroll state and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_enable <= 1'b0;
      units         <= UnitsReset;
      divisor       <= DivisorReset;
      timeout       <= TimeoutReset;
      acc_h         <= '0;
      acc_v         <= '0;
      last_time     <= '0;
      locked        <= 1'b0;
      vert          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCROLL_ENABLE: begin
            if (cfg_data[0] != scroll_enable) begin
              acc_h  <= '0;
              acc_v  <= '0;
              locked <= 1'b0;
              vert   <= 1'b0;
            end
            scroll_enable <= cfg_data[0];
          end
          CFG_UNITS_PER_DETENT: units   <= cfg_data[7:0];
          CFG_DETENT_DIVISOR:   divisor <= cfg_data[7:0];
          CFG_SNAP_TIMEOUT_MS:  timeout <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.add) begin
        if (locking && moving) begin
          last_time <= now_q;
        end
        if (release_lock) begin
          locked <= 1'b0;
          vert   <= 1'b0;
        end
      end
      if (cmd.commit && scroll_enable) begin
        acc_h  <= fin_h;
        acc_v  <= fin_v;
        locked <= locking ? locked_n : locked;
        vert   <= locking ? vert_n : vert;
      end
      out_valid <= cmd.commit || (out_valid && !out_ready);
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mx    <= motion_x;
      my    <= motion_y;
      wh    <= wheel_h_in;
      wv    <= wheel_v_in;
      now_q <= now_ms;
    end
    if (cmd.add) begin
      wah   <= add_h;
      wav   <= add_v;
      dq_h  <= magn(add_h);
      dq_v  <= magn(add_v);
      rem_h <= '0;
      rem_v <= '0;
      cnt   <= '0;
    end
    if (cmd.step) begin
      rem_h <= ge_h ? 8'(trial_h - {1'b0, div_eff}) : trial_h[7:0];
      rem_v <= ge_v ? 8'(trial_v - {1'b0, div_eff}) : trial_v[7:0];
      dq_h  <= {dq_h[AccW-2:0], ge_h};
      dq_v  <= {dq_v[AccW-2:0], ge_v};
      cnt   <= cnt + 1'b1;
    end
    if (cmd.commit) begin
      if (scroll_enable) begin
        out_x       <= '0;
        out_y       <= '0;
        out_wheel_h <= tick_h ? whl_h : wh;
        out_wheel_v <= tick_v ? whl_v : wv;
      end else begin
        out_x       <= mx;
        out_y       <= my;
        out_wheel_h <= wh;
        out_wheel_v <= wv;
      end
    end
  end

  // status back to the controller
  assign status.enable   = scroll_enable;
  assign status.div_last = (cnt == DivCntW'(DivSteps - 1));
  assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

[design/drag_scroll_accumulator.sv]
// Drag-scroll accumulator: turns pointer ball motion into wheel detents.
// motion (sink) takes one report per transaction: motion_x, motion_y,
// wheel_h_in, wheel_v_in and the millisecond time now_ms.
// report (source) gives exactly one result transaction per report.
// cfg (sink) writes a register by index; it is always ready and should
// only be used while no report is in flight.
// With scrolling enabled a report passes through capture at acceptance, then
// add, 32 steps of a restoring divider that handles both axes in parallel,
// and finish before report.valid rises. With scrolling disabled the report
// goes from capture straight to finish. A new report is accepted once the
// previous one has been moved into the output register, so a new report is
// never taken while the previous one is still being worked on.
// If the receiver stalls, the finished result holds in the output register
// and the next report is processed up to its finish step, where it waits.
// Reset clears the accumulators, the axis lock and the last motion time,
// and loads the register defaults: disabled, 1 unit per detent, divisor 6,
// snap timeout 100 ms.
`default_nettype none

module drag_scroll_accumulator import dsa_pkg::*; (
  input  wire           clk,
  input  wire           rst,
  dsa_motion_if.sink    motion,
  dsa_report_if.source  report,
  dsa_cfg_if.sink       cfg
);

  dsa_cmd_t    cmd;
  dsa_status_t status;

  // configuration writes are taken in any cycle
  assign cfg.ready = 1'b1;

  dsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (motion.valid),
    .in_ready (motion.ready),
    .status   (status),
    .cmd      (cmd)
  );

  dsa_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .motion_x    (motion.motion_x),
    .motion_y    (motion.motion_y),
    .wheel_h_in  (motion.wheel_h_in),
    .wheel_v_in  (motion.wheel_v_in),
    .now_ms      (motion.now_ms),
    .out_ready   (report.ready),
    .out_valid   (report.valid),
    .out_x       (report.out_x),
    .out_y       (report.out_y),
    .out_wheel_h (report.out_wheel_h),
    .out_wheel_v (report.out_wheel_v)
  );

  // one report in flight: no acceptance in the cycle after a transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (motion.valid && motion.ready) |=> !motion.ready)
    else $error("report accepted while previous one still in work");

  // motion outputs are zero for results made in scroll mode
  a_scroll_zero_motion: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && status.enable) |=> (report.out_x == '0 && report.out_y == '0))
    else $error("nonzero motion output in scroll mode");

  // the divider runs exactly its step count after the add stage
  a_div_length: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && status.div_last) |-> $past(cmd.add, DivSteps))
    else $error("division step count mismatch");

  // a result is only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (report.valid && !report.ready) |-> !cmd.commit)
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

[bench/scroll_report_checker.sv]
module scroll_report_checker import dsa_pkg::*; (
  input  wire   clk,
  input  wire   rst,
  dsa_motion_if motion,
  dsa_report_if report,
  dsa_cfg_if    cfg,
  output int    fail_count,
  output int    outstanding,
  output int    detent_count
);

  typedef struct packed {
    logic signed [MotionW-1:0] x;
    logic signed [MotionW-1:0] y;
    logic signed [WheelW-1:0]  wh;
    logic signed [WheelW-1:0]  wv;
  } wheel_report_t;

  localparam longint AccMax = (longint'(1) <<< (AccW - 1)) - 1;
  localparam longint AccMin = -(longint'(1) <<< (AccW - 1));

  // register copies
  logic             scroll_on;
  logic [7:0]       units;
  logic [7:0]       divisor;
  logic [TimeW-1:0] snap_ms;

  // scroll state
  logic signed [AccW-1:0] acc_h;
  logic signed [AccW-1:0] acc_v;
  logic [TimeW-1:0]       last_move_ms;
  logic                   locked;
  logic                   lock_vert;

  wheel_report_t awaited_reports[$];

  function automatic longint sat_acc(input longint v);
    if (v > AccMax) return AccMax;
    if (v < AccMin) return AccMin;
    return v;
  endfunction

  function automatic longint sat_wheel(input longint v);
    if (v > WheelLimit) return WheelLimit;
    if (v < -WheelLimit) return -WheelLimit;
    return v;
  endfunction

  function automatic void clear_scroll();
    acc_h = '0;
    acc_v = '0;
    locked = 1'b0;
    lock_vert = 1'b0;
  endfunction

  // one motion report in, one wheel report out; updates the scroll state
  function automatic wheel_report_t predict_report(
    input logic signed [MotionW-1:0] mx,
    input logic signed [MotionW-1:0] my,
    input logic signed [WheelW-1:0]  wh,
    input logic signed [WheelW-1:0]  wv,
    input logic [TimeW-1:0]          now
  );
    wheel_report_t r;
    longint ah;
    longint av;
    longint dv;
    longint th;
    longint tv;
    logic [TimeW-1:0] still;
    logic snap;
    r.x = mx;
    r.y = my;
    r.wh = wh;
    r.wv = wv;
    if (!scroll_on) return r;

    ah = sat_acc(longint'(acc_h) + longint'(mx) * longint'(units));
    av = sat_acc(longint'(acc_v) + longint'(my) * longint'(units));

    // still time releases the axis lock
    snap = (snap_ms != '0);
    if (snap) begin
      if (mx != 0 || my != 0) begin
        last_move_ms = now;
      end else if (locked) begin
        still = now - last_move_ms;
        if (still > snap_ms) begin
          ah = 0;
          av = 0;
          locked = 1'b0;
          lock_vert = 1'b0;
        end
      end
    end

    // whole detents, truncated toward zero
    dv = (divisor == '0) ? 64'sd1 : longint'(divisor);
    th = ah / dv;
    tv = av / dv;

    // first detent picks the axis, ties go vertical
    if (snap) begin
      if (!locked && (th != 0 || tv != 0)) begin
        locked = 1'b1;
        lock_vert = (tv < 0 ? -tv : tv) >= (th < 0 ? -th : th);
      end
      if (locked) begin
        if (lock_vert) begin
          th = 0;
          ah = 0;
        end else begin
          tv = 0;
          av = 0;
        end
      end
    end

    // report clamped detents, keep the rest
    r.x = '0;
    r.y = '0;
    if (th != 0) begin
      th = sat_wheel(th);
      r.wh = th[WheelW-1:0];
      ah -= th * dv;
    end
    if (tv != 0) begin
      tv = sat_wheel(tv);
      r.wv = tv[WheelW-1:0];
      av -= tv * dv;
    end
    if (th != 0 || tv != 0) detent_count++;

    acc_h = ah[AccW-1:0];
    acc_v = av[AccW-1:0];
    return r;
  endfunction

  function automatic int compare_field(input string name, input logic signed [7:0] want,
                                       input logic signed [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // watch the three channels at each edge
  always @(posedge clk) begin : watch
    wheel_report_t want;
    int bad;
    bad = 0;
    if (rst) begin
      scroll_on = 1'b0;
      units = UnitsReset;
      divisor = DivisorReset;
      snap_ms = TimeoutReset;
      clear_scroll();
      last_move_ms = '0;
      awaited_reports.delete();
    end else begin
      // register write transaction
      if (cfg.valid && cfg.ready) begin
        case (cfg_idx_t'(cfg.index))
          CFG_SCROLL_ENABLE: begin
            if (cfg.data[0] != scroll_on) clear_scroll();
            scroll_on = cfg.data[0];
          end
          CFG_UNITS_PER_DETENT: units = cfg.data[7:0];
          CFG_DETENT_DIVISOR:   divisor = cfg.data[7:0];
          CFG_SNAP_TIMEOUT_MS:  snap_ms = cfg.data[TimeW-1:0];
          default: ;
        endcase
      end

      // motion transaction
      if (motion.valid && motion.ready) begin
        awaited_reports.push_back(predict_report(motion.motion_x, motion.motion_y,
                                                 motion.wheel_h_in, motion.wheel_v_in,
                                                 motion.now_ms));
      end

      // report transaction
      if (report.valid && report.ready) begin
        if (awaited_reports.size() == 0) begin
          $display("%0t: report with none awaited, actual x %0d y %0d h %0d v %0d",
                   $time, report.out_x, report.out_y, report.out_wheel_h,
                   report.out_wheel_v);
          bad++;
        end else begin
          want = awaited_reports.pop_front();
          bad += compare_field("out_x", want.x, report.out_x);
          bad += compare_field("out_y", want.y, report.out_y);
          bad += compare_field("out_wheel_h", want.wh, report.out_wheel_h);
          bad += compare_field("out_wheel_v", want.wv, report.out_wheel_v);
        end
      end
    end
    fail_count <= fail_count + bad;
    outstanding <= awaited_reports.size();
  end

endmodule

[bench/testbench.sv]
module testbench;
  import dsa_pkg::*;

  logic clk;
  logic rst;

  dsa_motion_if motion_ch ();
  dsa_report_if report_ch ();
  dsa_cfg_if    cfg_ch ();

  int fail_count;
  int outstanding;
  int detent_count;

  drag_scroll_accumulator u_dut (
    .clk    (clk),
    .rst    (rst),
    .motion (motion_ch),
    .report (report_ch),
    .cfg    (cfg_ch)
  );

  scroll_report_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .motion       (motion_ch),
    .report       (report_ch),
    .cfg          (cfg_ch),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .detent_count (detent_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #(12 * 600000);
    $display("simulation failed");
    $finish;
  end

  bit               no_idle;
  int               stall_left = 0;
  logic [TimeW-1:0] cur_ms;
  logic [TimeW-1:0] last_move;
  logic [TimeW-1:0] snap_now;
  int               items_sent;
  int               settings_used;
  int               gest_left;
  int               gest_dx;
  int               gest_dy;

  // receiver stalls in short random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      report_ch.ready <= 1'b0;
    end else if (!no_idle && $urandom_range(149) == 0) begin
      stall_left <= $urandom_range(17);
      report_ch.ready <= 1'b0;
    end else begin
      report_ch.ready <= 1'b1;
    end
  end

  // hold off until every report is back
  task automatic wait_drained();
    motion_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDatW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // registers change only with nothing in flight; spare upper bits are random
  task automatic apply_setting(input logic en, input logic [7:0] u, input logic [7:0] d,
                               input logic [TimeW-1:0] t);
    wait_drained();
    write_reg(CFG_SCROLL_ENABLE, {15'($urandom), en});
    write_reg(CFG_UNITS_PER_DETENT, {8'($urandom), u});
    write_reg(CFG_DETENT_DIVISOR, {8'($urandom), d});
    write_reg(CFG_SNAP_TIMEOUT_MS, t);
    cfg_ch.valid <= 1'b0;
    snap_now = t;
    settings_used++;
  endtask

  task automatic send_report(input logic signed [MotionW-1:0] mx,
                             input logic signed [MotionW-1:0] my,
                             input logic signed [WheelW-1:0]  wh,
                             input logic signed [WheelW-1:0]  wv,
                             input logic [TimeW-1:0]          now);
    if (!no_idle && $urandom_range(99) < 15) begin
      motion_ch.valid <= 1'b0;
      repeat ($urandom_range(36, 1)) @(posedge clk);
    end
    motion_ch.valid <= 1'b1;
    motion_ch.motion_x <= mx;
    motion_ch.motion_y <= my;
    motion_ch.wheel_h_in <= wh;
    motion_ch.wheel_v_in <= wv;
    motion_ch.now_ms <= now;
    do @(posedge clk); while (!motion_ch.ready);
    items_sent++;
  endtask

  function automatic logic signed [7:0] clamp8(input int v);
    if (v > 127) return 8'sd127;
    if (v < -128) return -8'sd128;
    return 8'(v);
  endfunction

  // drag gestures with one dominant axis, still pauses and some noise
  task automatic random_report();
    int r;
    int mx;
    int my;
    logic [7:0] wh;
    logic [7:0] wv;
    r = $urandom_range(99);
    wh = ($urandom_range(2) == 0) ? 8'h00 : 8'($urandom);
    wv = ($urandom_range(2) == 0) ? 8'h00 : 8'($urandom);
    if (r < 8) begin
      cur_ms = 16'($urandom);
      mx = int'($urandom_range(255)) - 128;
      my = int'($urandom_range(255)) - 128;
    end else if (r < 24) begin
      mx = 0;
      my = 0;
      case ($urandom_range(3))
        0: cur_ms = last_move + snap_now;
        1: cur_ms = last_move + snap_now + 16'd1;
        default: cur_ms += 16'($urandom_range(200));
      endcase
    end else begin
      if (gest_left == 0) begin
        gest_left = $urandom_range(40, 3);
        gest_dx = int'($urandom_range(60)) - 30;
        gest_dy = int'($urandom_range(60)) - 30;
        if ($urandom_range(1) == 0) gest_dx = gest_dx / 8;
        else gest_dy = gest_dy / 8;
        if ($urandom_range(9) == 0) gest_dx = $urandom_range(1) ? 127 : -128;
        if ($urandom_range(9) == 0) gest_dy = $urandom_range(1) ? 127 : -128;
      end
      gest_left--;
      mx = clamp8(gest_dx + int'($urandom_range(4)) - 2);
      my = clamp8(gest_dy + int'($urandom_range(4)) - 2);
      cur_ms += 16'($urandom_range(3, 1));
    end
    if (mx != 0 || my != 0) last_move = cur_ms;
    send_report(8'(mx), 8'(my), wh, wv, cur_ms);
  endtask

  // stimulus
  initial begin
    rst <= 1'b1;
    no_idle <= 1'b0;
    motion_ch.valid <= 1'b0;
    motion_ch.motion_x <= '0;
    motion_ch.motion_y <= '0;
    motion_ch.wheel_h_in <= '0;
    motion_ch.wheel_v_in <= '0;
    motion_ch.now_ms <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_SCROLL_ENABLE;
    cfg_ch.data <= '0;
    cur_ms = '0;
    last_move = '0;
    snap_now = TimeoutReset;
    items_sent = 0;
    settings_used = 0;
    gest_left = 0;
    gest_dx = 0;
    gest_dy = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // pass-through after reset
    send_report(-8'sd128, 8'sd127, -8'sd128, 8'sd127, 16'hffff);
    send_report(8'sd127, -8'sd128, 8'sd127, -8'sd127, 16'h0000);
    send_report(8'sd0, 8'sd1, 8'sd0, 8'sd0, 16'h5555);

    // default factors with scrolling on
    apply_setting(1'b1, 8'd1, 8'd6, 16'd100);
    send_report(8'sd3, 8'sd2, 8'sd9, -8'sd9, 16'd1000);
    send_report(8'sd4, 8'sd1, 8'sd9, -8'sd9, 16'd1001);    // horizontal lock
    send_report(8'sd5, 8'sd30, 8'sd9, -8'sd9, 16'd1002);   // other axis dropped
    send_report(8'sd0, 8'sd0, 8'sd9, -8'sd9, 16'd1102);    // still exactly timeout
    send_report(8'sd0, 8'sd0, 8'sd9, -8'sd9, 16'd1103);    // lock released
    send_report(8'sd12, 8'sd12, 8'sd9, -8'sd9, 16'd1104);  // tie goes vertical
    send_report(-8'sd7, -8'sd20, 8'sd9, -8'sd9, 16'd1105); // negative, toward zero
    send_report(8'sd3, 8'sd0, 8'sd0, 8'sd0, 16'd65530);
    send_report(8'sd0, 8'sd0, 8'sd0, 8'sd0, 16'd194);      // still time across wrap

    // saturated detents with remainder carry
    apply_setting(1'b1, 8'd255, 8'd1, 16'd100);
    send_report(8'sd127, 8'sd10, 8'sd0, 8'sd0, 16'd300);
    send_report(8'sd0, 8'sd0, 8'sd0, 8'sd0, 16'd301);
    send_report(-8'sd128, -8'sd128, -8'sd128, -8'sd128, 16'd302);

    // locking off, both axes scroll
    apply_setting(1'b1, 8'd5, 8'd3, 16'd0);
    send_report(8'sd10, -8'sd10, 8'sd1, 8'sd1, 16'd400);
    send_report(8'sd0, 8'sd0, -8'sd1, -8'sd1, 16'd5000);

    // zero units and zero divisor
    apply_setting(1'b0, 8'd1, 8'd6, 16'd100);
    apply_setting(1'b1, 8'd0, 8'd0, 16'd65535);
    send_report(8'sd100, 8'sd100, 8'sd7, 8'sd7, 16'd10);
    apply_setting(1'b1, 8'd3, 8'd0, 16'd65535);
    send_report(8'sd1, -8'sd1, 8'sd0, 8'sd0, 16'd20);
    send_report(8'sd0, 8'sd0, 8'sd0, 8'sd0, 16'd65535);

    // random phases over a range of settings
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: apply_setting(1'b1, 8'd1, 8'd6, 16'd100);
        1: apply_setting(1'b0, 8'd200, 8'd100, 16'd50);
        2: apply_setting(1'b1, 8'd255, 8'd1, 16'd0);
        3: apply_setting(1'b1, 8'd0, 8'd255, 16'd65535);
        4: apply_setting(1'b1, 8'($urandom_range(16, 1)), 8'($urandom_range(32, 1)),
                         16'($urandom_range(30, 1)));
        5: apply_setting(1'b1, 8'd32, 8'd255, 16'd1);
        default: apply_setting(1'b1, 8'd8, 8'd0, 16'd100);
      endcase
      no_idle <= (p == 2);
      repeat (120) begin
        if ($urandom_range(59) == 0) wait_drained();
        random_report();
      end
    end

    // drain and settle
    wait_drained();
    repeat (40) @(posedge clk);

    $display("sent %0d motion reports under %0d register settings", items_sent,
             settings_used);
    $display("%0d of them carried wheel detents", detent_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
